/* rtl/core/bba_pkg.sv */
// types and constants shared by the bitmap block allocator
package bba_pkg;

  localparam int unsigned MAX_BLOCKS = 1024;
  localparam int unsigned BLK_W      = 10;
  localparam int unsigned CNT_W      = 11;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned POS_W      = $clog2(WORD_W);
  localparam int unsigned NUM_WORDS  = MAX_BLOCKS / WORD_W;
  localparam int unsigned ADDR_W     = $clog2(NUM_WORDS);

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_MARK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [BLK_W-1:0] block_index;
  } in_t;

  typedef struct packed {
    logic             status;
    logic [BLK_W-1:0] result_block;
    logic [CNT_W-1:0] free_count;
  } out_t;

endpackage

/* rtl/core/bitmap_block_allocator.sv */
// first-fit block allocator over a used/free bitmap kept in a word-wide memory
// free and mark-used go from accept through ST_SCAN and ST_RESP into the output register
// allocate stays in ST_SCAN a bitmap word at a time, up to 32 words, until a free bit or the last word
// a new item is taken only in ST_IDLE, once the reply is in the output register; a full output register stalls it
// reset and a block-count write clear the map at once through per-row valid bits
// reset loads a block count of 1024 and a free count of 1024
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output out_t             out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  state_e               state_q, state_d;
  logic [1:0]           op_q, op_d;
  logic [BLK_W-1:0]     idx_q, idx_d;
  logic [BLK_W-1:0]     start_q, start_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [CNT_W-1:0]     num_q, num_d;
  logic [CNT_W-1:0]     free_q, free_d;
  logic [NUM_WORDS-1:0] row_valid_q, row_valid_d;
  logic                 rd_valid_q;
  logic [WORD_W-1:0]    rdata_q;
  logic [WORD_W-1:0]    mem_q [NUM_WORDS];
  out_t                 res_q, res_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 mem_we;
  logic [WORD_W-1:0]    mem_wdata;
  logic [WORD_W-1:0]    word;
  logic [BLK_W-1:0]     base;
  logic [CNT_W-1:0]     lim;
  logic [WORD_W-1:0]    lo_mask, hi_mask, cand, bit_sel;
  logic                 found;
  logic [POS_W-1:0]     pos;
  logic                 last_word;
  logic [CNT_W:0]       next_base;
  logic                 idx_ok;
  logic                 out_free;
  logic                 cfg_fire, in_fire;
  logic [BLK_W-1:0]     in_start;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_start    = (in_data_i.block_index == '0) ? BLK_W'(1) : in_data_i.block_index;

  // datapath for the word under test
  always_comb begin
    word      = rd_valid_q ? rdata_q : '0;
    base      = {addr_q, POS_W'(0)};
    lim       = (num_q > {1'b0, base}) ? (num_q - {1'b0, base}) : '0;
    hi_mask   = (lim >= CNT_W'(WORD_W)) ? '1 : ((WORD_W'(1) << lim[POS_W-1:0]) - WORD_W'(1));
    lo_mask   = (addr_q == start_q[BLK_W-1:POS_W]) ? ('1 << start_q[POS_W-1:0]) : '1;
    cand      = ~word & lo_mask & hi_mask;
    found     = |cand;
    pos       = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        pos = POS_W'(j);
      end
    end
    next_base = {2'b0, base} + (CNT_W + 1)'(WORD_W);
    last_word = (addr_q == ADDR_W'(NUM_WORDS - 1)) || (next_base >= {1'b0, num_q});
    bit_sel   = WORD_W'(1) << idx_q[POS_W-1:0];
    idx_ok    = {1'b0, idx_q} < num_q;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    idx_d       = idx_q;
    start_d     = start_q;
    addr_d      = addr_q;
    num_d       = num_q;
    free_d      = free_q;
    row_valid_d = row_valid_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_wdata   = word;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (cfg_fire) begin
          num_d       = (cfg_data_i > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_data_i;
          free_d      = num_d;
          row_valid_d = '0;
        end
        if (in_fire) begin
          op_d    = in_data_i.operation;
          idx_d   = in_data_i.block_index;
          start_d = in_start;
          addr_d  = in_start[BLK_W-1:POS_W];
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        res_d.status       = 1'b1;
        res_d.result_block = '0;
        state_d            = ST_RESP;
        case (op_q)
          OP_ALLOC: begin
            if (found) begin
              mem_we             = 1'b1;
              mem_wdata          = word | (WORD_W'(1) << pos);
              if (free_q != '0) begin
                free_d = free_q - CNT_W'(1);
              end
              res_d.status       = 1'b0;
              res_d.result_block = base | BLK_W'(pos);
            end else if (!last_word) begin
              addr_d  = addr_q + ADDR_W'(1);
              state_d = ST_SCAN;
            end
          end
          OP_FREE: begin
            if (idx_ok && idx_q != '0) begin
              if ((word & bit_sel) != '0) begin
                mem_we    = 1'b1;
                mem_wdata = word & ~bit_sel;
                if (free_q < num_q) begin
                  free_d = free_q + CNT_W'(1);
                end
              end
              res_d.status       = 1'b0;
              res_d.result_block = idx_q;
            end
          end
          OP_MARK: begin
            if (idx_ok) begin
              if ((word & bit_sel) == '0) begin
                mem_we    = 1'b1;
                mem_wdata = word | bit_sel;
                if (free_q != '0) begin
                  free_d = free_q - CNT_W'(1);
                end
              end
              res_d.status       = 1'b0;
              res_d.result_block = idx_q;
            end
          end
          default: begin
          end
        endcase
        res_d.free_count = free_d;
        if (mem_we) begin
          row_valid_d[addr_q] = 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_q       <= CNT_W'(MAX_BLOCKS);
      free_q      <= CNT_W'(MAX_BLOCKS);
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_q       <= num_d;
      free_q      <= free_d;
      row_valid_q <= row_valid_d;
      rd_valid_q  <= row_valid_d[addr_d];
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    idx_q   <= idx_d;
    start_q <= start_d;
    addr_q  <= addr_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  // bitmap memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr_q] <= mem_wdata;
    end
    rdata_q <= mem_q[addr_d];
  end

endmodule

/* bench/tb.sv */
// testbench for the bitmap block allocator: directed edge cases, then random traffic
`timescale 1ns / 1ps

module tb
  import bba_pkg::*;
();

  localparam int unsigned IDLE_LIMIT = 4000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_t              in_data;
  logic             out_valid;
  logic             out_ready;
  out_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  logic             steady;
  int unsigned      mismatches;
  int unsigned      idle_cycles;

  // predictor state
  logic             used_map [MAX_BLOCKS];
  int unsigned      block_total;
  logic [CNT_W-1:0] free_left;
  out_t             expected_replies [$];

  bitmap_block_allocator uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0d, want %0d", what, got, want);
    mismatches++;
  endtask

  task automatic load_block_count_model(input logic [CNT_W-1:0] value);
    block_total = (value > MAX_BLOCKS) ? MAX_BLOCKS : value;
    foreach (used_map[i]) used_map[i] = 1'b0;
    free_left = block_total[CNT_W-1:0];
  endtask

  function automatic out_t predict_block_op(input in_t item);
    out_t        reply;
    int unsigned pos;
    reply = '0;
    reply.status = 1'b1;
    case (op_e'(item.operation))
      OP_ALLOC: begin
        pos = (item.block_index == 0) ? 1 : item.block_index;
        while (pos < block_total && used_map[pos]) pos++;
        if (pos < block_total) begin
          used_map[pos] = 1'b1;
          if (free_left > 0) free_left--;
          reply.status = 1'b0;
          reply.result_block = pos[BLK_W-1:0];
        end
      end
      OP_FREE: begin
        if (item.block_index != 0 && item.block_index < block_total) begin
          if (used_map[item.block_index]) begin
            used_map[item.block_index] = 1'b0;
            if (free_left < block_total) free_left++;
          end
          reply.status = 1'b0;
          reply.result_block = item.block_index;
        end
      end
      OP_MARK: begin
        if (item.block_index < block_total) begin
          if (!used_map[item.block_index]) begin
            used_map[item.block_index] = 1'b1;
            if (free_left > 0) free_left--;
          end
          reply.status = 1'b0;
          reply.result_block = item.block_index;
        end
      end
      default: ;
    endcase
    reply.free_count = free_left;
    return reply;
  endfunction

  function automatic int unsigned pick_used_block(input int unsigned lim);
    int unsigned cand;
    for (int t = 0; t < 8; t++) begin
      cand = $urandom_range(lim - 1);
      if (used_map[cand]) return cand;
    end
    return $urandom_range(MAX_BLOCKS - 1);
  endfunction

  task automatic send_op(input op_e op, input int unsigned idx);
    in_t item;
    item.operation   = op;
    item.block_index = idx[BLK_W-1:0];
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_replies.push_back(predict_block_op(item));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_block_count(input logic [CNT_W-1:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    load_block_count_model(value);
  endtask

  task automatic test_full_map_edges();
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 1023);
    send_op(OP_ALLOC, 1023);
    send_op(OP_MARK, 0);
    send_op(OP_FREE, 0);
    send_op(OP_FREE, 1023);
    send_op(OP_FREE, 1023);
    send_op(OP_MARK, 5);
    send_op(OP_MARK, 5);
    send_op(OP_ALLOC, 4);
    send_op(OP_NONE, 1023);
  endtask

  task automatic test_tiny_maps();
    write_block_count(0);
    send_op(OP_ALLOC, 0);
    send_op(OP_FREE, 1);
    send_op(OP_MARK, 0);
    write_block_count(1);
    send_op(OP_ALLOC, 0);
    send_op(OP_MARK, 0);
    send_op(OP_FREE, 0);
    write_block_count(2);
    send_op(OP_ALLOC, 0);
    send_op(OP_ALLOC, 0);
    send_op(OP_FREE, 1);
    send_op(OP_MARK, 2);
    write_block_count(2047);
    send_op(OP_MARK, 1023);
    send_op(OP_FREE, 1023);
  endtask

  task automatic run_random_phase(input logic [CNT_W-1:0] count, input int items,
                                  input bit no_gaps, input bit pause);
    int unsigned lim;
    int unsigned pick;
    int unsigned idx;
    op_e         op;
    write_block_count(count);
    steady <= no_gaps;
    lim = (block_total == 0) ? 1 : block_total;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        op  = OP_ALLOC;
        idx = ($urandom_range(3) == 0) ? 0 : $urandom_range(lim - 1);
      end else if (pick < 75) begin
        op  = OP_FREE;
        idx = pick_used_block(lim);
      end else if (pick < 88) begin
        op  = OP_MARK;
        idx = $urandom_range(lim - 1);
      end else if (pick < 93) begin
        op  = OP_NONE;
        idx = $urandom_range(MAX_BLOCKS - 1);
      end else begin
        op  = op_e'($urandom_range(3));
        idx = $urandom_range(MAX_BLOCKS - 1);
      end
      if (pause && n == items / 2) wait_drained();
      send_op(op, idx);
    end
    steady <= 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(1024, 80, 1'b0, 1'b0);
    run_random_phase(40, 80, 1'b0, 1'b0);
    run_random_phase(7, 60, 1'b0, 1'b0);
    run_random_phase(300, 70, 1'b1, 1'b0);
    run_random_phase(2, 40, 1'b0, 1'b0);
    run_random_phase(64, 80, 1'b0, 1'b1);
    run_random_phase(1025, 60, 1'b0, 1'b0);
    run_random_phase($urandom_range(100, 1), 80, 1'b0, 1'b0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 36);
    end
  end

  always @(posedge clk) begin : check_replies
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("word with nothing expected", out_data, 0);
      end else begin
        want = expected_replies.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", out_data.status, want.status);
        if (out_data.result_block !== want.result_block)
          report_mismatch("result_block", out_data.result_block, want.result_block);
        if (out_data.free_count !== want.free_count)
          report_mismatch("free_count", out_data.free_count, want.free_count);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)
                 || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    steady     <= 1'b0;
    mismatches = 0;
    load_block_count_model(1024);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_map_edges();
    test_tiny_maps();
    test_random_traffic();

    wait_drained();
    repeat (40) @(posedge clk);
    if (expected_replies.size() != 0)
      report_mismatch("words never delivered", expected_replies.size(), 0);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
